### rtl/core/pmul_pkg.sv
package pmul_pkg;

  localparam int MAX_TERMS = 32;

  localparam int ACTION_W  = 2;
  localparam int EXP_W     = 5;
  localparam int COEF_W    = 32;
  // Product exponents must fit the exponent field.
  localparam int EXP_LIMIT = 32;

  localparam int IN_DATA_W  = ((EXP_W + COEF_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((EXP_W + COEF_W + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE_A  = 2'd0,
    ACT_WRITE_B  = 2'd1,
    ACT_MULTIPLY = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_e;

  typedef struct packed {
    logic issue;
    logic a_vld;
    logic b_vld;
    logic clr;
  } mac_ctl_t;

endpackage

### rtl/core/polynomial_multiplier_core.sv
// Term writes and clears produce no result. A multiply first scans both stores
// for their degrees; if the product degree does not fit, it gives one error result,
// else for each product exponent k it runs a setup step, issues the pairs of k
// and drains the multiply-accumulate pipeline; output stalls hold it back.
// The single read port of each coefficient RAM sets one pair per cycle.
// Reset (rst_ni low, asynchronous) empties both stores and the output.
module polynomial_multiplier_core #(
  parameter int MaxTerms = pmul_pkg::MAX_TERMS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // exponent [4:0], coefficient [36:5], zero padding above
  input  logic [pmul_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // action [1:0]
  input  logic [pmul_pkg::ACTION_W-1:0]   s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // product_exponent [4:0], product_coefficient [36:5], zero padding above
  output logic [pmul_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,
  // status [0]
  output logic                           m_axis_tuser
);

  import pmul_pkg::*;

  localparam int IdxW = $clog2(MaxTerms);
  localparam int PadW = OUT_DATA_W - EXP_W - COEF_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_SETUP,
    S_ISSUE,
    S_DRAIN
  } state_e;

  state_e                state_q;
  logic [IdxW-1:0]       cnt_q, da_q, db_q, k_q, i_q, hi_q;
  logic [MaxTerms-1:0]   vld_a_q, vld_b_q, nz_a_q, nz_b_q;
  logic                  m_valid_q, m_last_q, m_status_q;
  logic [EXP_W-1:0]      m_exp_q;
  logic [COEF_W-1:0]     m_coef_q;

  logic                  in_acc, wr_ok, out_free, dp_err, last_k, mac_busy, m_load;
  action_e               in_act;
  logic [EXP_W-1:0]      in_exp;
  logic [COEF_W-1:0]     in_coef;
  logic [IdxW-1:0]       wr_addr, b_addr, lo, hi;
  logic [IdxW:0]         dp;
  logic [COEF_W-1:0]     a_rdata, b_rdata, mac_sum;
  mac_ctl_t              mac_ctl;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_act   = action_e'(s_axis_tuser);
  assign in_exp   = s_axis_tdata[EXP_W-1:0];
  assign in_coef  = s_axis_tdata[EXP_W+COEF_W-1:EXP_W];
  assign wr_ok    = int'(in_exp) < MaxTerms;
  assign wr_addr  = IdxW'(in_exp);

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !m_valid_q || m_axis_tready;

  assign dp     = {1'b0, da_q} + {1'b0, db_q};
  assign dp_err = (int'(dp) >= MaxTerms) || (int'(dp) >= EXP_LIMIT);
  assign last_k = ({1'b0, k_q} == dp);

  // The output register takes a new item in this cycle.
  assign m_load = ((state_q == S_CHECK) && dp_err && out_free) ||
                  ((state_q == S_DRAIN) && !mac_busy && out_free);

  // Pair range for exponent k: i from max(0, k-degB) to min(k, degA).
  assign lo     = (k_q >= db_q) ? (k_q - db_q) : '0;
  assign hi     = (k_q <= da_q) ? k_q : da_q;
  assign b_addr = k_q - i_q;

  assign mac_ctl.issue = (state_q == S_ISSUE);
  assign mac_ctl.a_vld = vld_a_q[i_q];
  assign mac_ctl.b_vld = vld_b_q[b_addr];
  assign mac_ctl.clr   = (state_q == S_SETUP);

  pmul_ram #(
    .Width (COEF_W),
    .Depth (MaxTerms)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_act == ACT_WRITE_A) && wr_ok),
    .waddr_i (wr_addr),
    .wdata_i (in_coef),
    .raddr_i (i_q),
    .rdata_o (a_rdata)
  );

  pmul_ram #(
    .Width (COEF_W),
    .Depth (MaxTerms)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_act == ACT_WRITE_B) && wr_ok),
    .waddr_i (wr_addr),
    .wdata_i (in_coef),
    .raddr_i (b_addr),
    .rdata_o (b_rdata)
  );

  pmul_mac #(
    .MaxTerms (MaxTerms)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .a_data_i (a_rdata),
    .b_data_i (b_rdata),
    .busy_o   (mac_busy),
    .sum_o    (mac_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      da_q       <= '0;
      db_q       <= '0;
      k_q        <= '0;
      i_q        <= '0;
      hi_q       <= '0;
      vld_a_q    <= '0;
      vld_b_q    <= '0;
      nz_a_q     <= '0;
      nz_b_q     <= '0;
      m_valid_q  <= 1'b0;
      m_last_q   <= 1'b0;
      m_status_q <= 1'b0;
      m_exp_q    <= '0;
      m_coef_q   <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && !m_load) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_act)
              ACT_WRITE_A: begin
                if (wr_ok) begin
                  vld_a_q[wr_addr] <= 1'b1;
                  nz_a_q[wr_addr]  <= |in_coef;
                end
              end
              ACT_WRITE_B: begin
                if (wr_ok) begin
                  vld_b_q[wr_addr] <= 1'b1;
                  nz_b_q[wr_addr]  <= |in_coef;
                end
              end
              ACT_MULTIPLY: begin
                cnt_q   <= '0;
                da_q    <= '0;
                db_q    <= '0;
                state_q <= S_SCAN;
              end
              ACT_CLEAR: begin
                vld_a_q <= '0;
                vld_b_q <= '0;
                nz_a_q  <= '0;
                nz_b_q  <= '0;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // The last nonzero entry seen is the degree.
          if (nz_a_q[cnt_q]) begin
            da_q <= cnt_q;
          end
          if (nz_b_q[cnt_q]) begin
            db_q <= cnt_q;
          end
          if (cnt_q == IdxW'(MaxTerms - 1)) begin
            state_q <= S_CHECK;
          end else begin
            cnt_q <= cnt_q + IdxW'(1);
          end
        end
        S_CHECK: begin
          if (dp_err) begin
            if (out_free) begin
              m_valid_q  <= 1'b1;
              m_exp_q    <= '0;
              m_coef_q   <= '0;
              m_last_q   <= 1'b1;
              m_status_q <= 1'b1;
              state_q    <= S_IDLE;
            end
          end else begin
            k_q     <= '0;
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          i_q     <= lo;
          hi_q    <= hi;
          state_q <= S_ISSUE;
        end
        S_ISSUE: begin
          if (i_q == hi_q) begin
            state_q <= S_DRAIN;
          end else begin
            i_q <= i_q + IdxW'(1);
          end
        end
        S_DRAIN: begin
          if (!mac_busy && out_free) begin
            m_valid_q  <= 1'b1;
            m_exp_q    <= EXP_W'(k_q);
            m_coef_q   <= mac_sum;
            m_last_q   <= last_k;
            m_status_q <= 1'b0;
            if (last_k) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + IdxW'(1);
              state_q <= S_SETUP;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, m_coef_q, m_exp_q};
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_status_q;

  // A new item is only taken once the accumulate pipeline has emptied.
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !mac_busy)
    else $error("item accepted while the accumulate pipeline is busy");

  // A product coefficient is loaded only from a fully drained sum.
  a_load_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) && $past(state_q == S_DRAIN) |-> $past(!mac_busy))
    else $error("product loaded before the accumulator settled");

  // An error result always closes the multiply.
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("error result without last");

  // Pair reads stay inside both polynomials.
  a_pair_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISSUE) |-> (i_q <= da_q) && (b_addr <= db_q) && (i_q <= hi_q))
    else $error("coefficient pair read outside the degrees");

  // The accumulator is cleared only while no product is in flight.
  a_clear_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctl.clr |-> !mac_busy)
    else $error("accumulator cleared with products in flight");

endmodule

### rtl/core/pmul_ram.sv
module pmul_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/pmul_mac.sv
module pmul_mac #(
  parameter int MaxTerms = pmul_pkg::MAX_TERMS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pmul_pkg::mac_ctl_t         ctl_i,
  input  logic [pmul_pkg::COEF_W-1:0] a_data_i,
  input  logic [pmul_pkg::COEF_W-1:0] b_data_i,
  output logic                       busy_o,
  output logic [pmul_pkg::COEF_W-1:0] sum_o
);

  import pmul_pkg::*;

  localparam int ProdW = 2 * COEF_W;
  // Enough headroom for MaxTerms full-scale products in one sum.
  localparam int AccW  = ProdW + $clog2(MaxTerms);
  localparam int Frac  = 16;
  localparam int TopLo = COEF_W + Frac - 1;
  localparam logic [COEF_W-1:0] SatMax = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] SatMin = {1'b1, {(COEF_W-1){1'b0}}};

  logic                     v1_q, v2_q, ga_q, gb_q;
  logic signed [COEF_W-1:0] op_a, op_b;
  logic signed [ProdW-1:0]  prod_d, prod_q;
  logic signed [AccW-1:0]   acc_d, acc_q;
  logic                     in_range;

  // Entries never written since the last clear read as zero.
  assign op_a   = ga_q ? signed'(a_data_i) : '0;
  assign op_b   = gb_q ? signed'(b_data_i) : '0;
  assign prod_d = op_a * op_b;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (v2_q) begin
      acc_d = acc_q + AccW'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ga_q <= 1'b0;
      gb_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.issue;
      v2_q <= v1_q;
      ga_q <= ctl_i.a_vld;
      gb_q <= ctl_i.b_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  // Dropping 16 fraction bits floors the sum; it fits when every bit above
  // the kept field equals the sign.
  assign in_range = (&acc_q[AccW-1:TopLo]) || !(|acc_q[AccW-1:TopLo]);
  assign sum_o    = in_range ? acc_q[TopLo:Frac] : (acc_q[AccW-1] ? SatMin : SatMax);
  assign busy_o   = v1_q || v2_q;

endmodule

### tb/pmul_product_checker.sv
`timescale 1ns / 1ps

module pmul_product_checker #(
  parameter int MaxTerms = pmul_pkg::MAX_TERMS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // exponent [4:0], coefficient [36:5], zero padding above
  input  logic [pmul_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // action [1:0]
  input  logic [pmul_pkg::ACTION_W-1:0]   s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // product_exponent [4:0], product_coefficient [36:5], zero padding above
  input  logic [pmul_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tlast,
  // status [0]
  input  logic                            m_axis_tuser,
  output int                              fail_count_o,
  output int                              pending_o
);

  import pmul_pkg::*;

  typedef struct packed {
    logic [EXP_W-1:0]  exponent;
    logic [COEF_W-1:0] coefficient;
    logic              last;
    logic              status;
  } product_t;

  localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] SAT_LO = -128'sh8000_0000;

  logic signed [COEF_W-1:0] terms_a [MaxTerms];
  logic signed [COEF_W-1:0] terms_b [MaxTerms];
  product_t                 pending_products [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic clear_terms();
    for (int k = 0; k < MaxTerms; k++) begin
      terms_a[k] = '0;
      terms_b[k] = '0;
    end
  endtask

  // Convolves both term stores exactly, then floors each sum to Q16.16 and saturates.
  task automatic predict_products();
    int                 deg_a;
    int                 deg_b;
    int                 deg_p;
    logic signed [127:0] sums [MaxTerms];
    logic signed [127:0] scaled;
    longint             pair;
    product_t           prod;
    deg_a = 0;
    deg_b = 0;
    for (int k = 0; k < MaxTerms; k++) begin
      if (terms_a[k] != 0) deg_a = k;
      if (terms_b[k] != 0) deg_b = k;
    end
    deg_p = deg_a + deg_b;
    if (deg_p >= MaxTerms || deg_p >= EXP_LIMIT) begin
      prod.exponent    = '0;
      prod.coefficient = '0;
      prod.last        = 1'b1;
      prod.status      = 1'b1;
      pending_products.push_back(prod);
    end else begin
      for (int k = 0; k < MaxTerms; k++) sums[k] = '0;
      for (int i = 0; i <= deg_a; i++) begin
        for (int j = 0; j <= deg_b; j++) begin
          pair = longint'(terms_a[i]) * longint'(terms_b[j]);
          sums[i + j] = sums[i + j] + pair;
        end
      end
      for (int k = 0; k <= deg_p; k++) begin
        scaled = sums[k] >>> 16;
        if (scaled > SAT_HI) begin
          prod.coefficient = 32'h7FFF_FFFF;
        end else if (scaled < SAT_LO) begin
          prod.coefficient = 32'h8000_0000;
        end else begin
          prod.coefficient = scaled[COEF_W-1:0];
        end
        prod.exponent = k[EXP_W-1:0];
        prod.last     = (k == deg_p);
        prod.status   = 1'b0;
        pending_products.push_back(prod);
      end
    end
  endtask

  task automatic check_product();
    product_t want;
    product_t seen;
    seen.exponent    = m_axis_tdata[EXP_W-1:0];
    seen.coefficient = m_axis_tdata[EXP_W+COEF_W-1:EXP_W];
    seen.last        = m_axis_tlast;
    seen.status      = m_axis_tuser;
    if (pending_products.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) begin
        $display("%0t: unexpected item: exp %0d coef %0d last %0b status %0b", $realtime,
                 seen.exponent, $signed(seen.coefficient), seen.last, seen.status);
      end
    end else begin
      want = pending_products.pop_front();
      if (seen !== want) begin
        fail_count_o++;
        if (fail_count_o <= 10) begin
          $display("%0t: mismatch: expected exp %0d coef %0d last %0b status %0b", $realtime,
                   want.exponent, $signed(want.coefficient), want.last, want.status);
          $display("%0t:           actual   exp %0d coef %0d last %0b status %0b", $realtime,
                   seen.exponent, $signed(seen.coefficient), seen.last, seen.status);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_terms();
      pending_products.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_product();
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          ACT_WRITE_A: begin
            if (s_axis_tdata[EXP_W-1:0] < MaxTerms) begin
              terms_a[s_axis_tdata[EXP_W-1:0]] = s_axis_tdata[EXP_W+COEF_W-1:EXP_W];
            end
          end
          ACT_WRITE_B: begin
            if (s_axis_tdata[EXP_W-1:0] < MaxTerms) begin
              terms_b[s_axis_tdata[EXP_W-1:0]] = s_axis_tdata[EXP_W+COEF_W-1:EXP_W];
            end
          end
          ACT_MULTIPLY: predict_products();
          default: clear_terms();
        endcase
      end
    end
    pending_o = pending_products.size();
  end

endmodule

### tb/polynomial_multiplier_core_tb.sv
`timescale 1ns / 1ps

module polynomial_multiplier_core_tb;
  import pmul_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 310;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [ACTION_W-1:0]   s_axis_tuser = ACT_WRITE_A;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  int fail_count;
  int pending_count;
  int items_sent = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  polynomial_multiplier_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  pmul_product_checker product_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 17);
  end

  task automatic send_item(input action_e act, input logic [EXP_W-1:0] expo,
                           input logic [COEF_W-1:0] coef);
    if (!no_idle && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {{(IN_DATA_W - EXP_W - COEF_W){1'b0}}, coef, expo};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Holds the sender back until every outstanding product has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
  endtask

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return COEF_W'($signed($urandom_range(8 << 16)) - (4 << 16));
      3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      4: return '0;
      default: return COEF_W'($signed($urandom_range(511)) - 256);
    endcase
  endfunction

  // Mostly clear, load a few terms of low degree and multiply; now and then just noise.
  task automatic random_sequence();
    int      top_exp;
    action_e act;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(3, 1)) begin
        act = action_e'($urandom_range(3));
        send_item(act, EXP_W'($urandom), $urandom);
      end
    end else begin
      if ($urandom_range(99) < 80) send_item(ACT_CLEAR, EXP_W'($urandom), $urandom);
      top_exp = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(5);
      repeat ($urandom_range(5, 1)) begin
        act = $urandom_range(1) ? ACT_WRITE_B : ACT_WRITE_A;
        send_item(act, EXP_W'($urandom_range(top_exp)), rand_coef());
      end
      send_item(ACT_MULTIPLY, EXP_W'($urandom), $urandom);
    end
  endtask

  initial begin
    int directed_items;
    int seq_count;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty stores give a single zero coefficient.
    send_item(ACT_MULTIPLY, 5'd0, 32'h0);
    // Saturation in both directions and flooring of a tiny negative product.
    send_item(ACT_WRITE_A, 5'd0, 32'h7FFF_FFFF);
    send_item(ACT_WRITE_B, 5'd0, 32'h7FFF_FFFF);
    send_item(ACT_MULTIPLY, 5'd31, 32'hFFFF_FFFF);
    send_item(ACT_WRITE_A, 5'd0, 32'h8000_0000);
    send_item(ACT_MULTIPLY, 5'd0, 32'h0);
    send_item(ACT_WRITE_B, 5'd0, 32'h8000_0000);
    send_item(ACT_MULTIPLY, 5'd0, 32'h0);
    send_item(ACT_WRITE_A, 5'd0, 32'hFFFF_FFFF);
    send_item(ACT_WRITE_B, 5'd0, 32'h0000_0001);
    send_item(ACT_MULTIPLY, 5'd0, 32'h0);
    // Degree two product, then a product degree past the store.
    send_item(ACT_WRITE_A, 5'd1, 32'h0001_0000);
    send_item(ACT_WRITE_B, 5'd1, 32'hFFFE_0000);
    send_item(ACT_MULTIPLY, 5'd0, 32'h0);
    send_item(ACT_WRITE_A, 5'd31, 32'h0001_8000);
    send_item(ACT_MULTIPLY, 5'd0, 32'h0);
    // Zeroing B's top term drops the degree back to 31: a full run of results, twice.
    send_item(ACT_WRITE_B, 5'd1, 32'h0);
    send_item(ACT_MULTIPLY, 5'd0, 32'h0);
    send_item(ACT_MULTIPLY, 5'd0, 32'h0);
    send_item(ACT_CLEAR, 5'd31, 32'hFFFF_FFFF);
    send_item(ACT_MULTIPLY, 5'd0, 32'h0);
    send_item(ACT_WRITE_B, 5'd31, 32'h1234_5678);
    send_item(ACT_WRITE_A, 5'd0, 32'hFFFF_0000);
    send_item(ACT_MULTIPLY, 5'd0, 32'h0);
    wait_drained();
    directed_items = items_sent;

    seq_count = 0;
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      no_idle = (seq_count >= 12 && seq_count < 22);
      random_sequence();
      seq_count++;
      if (seq_count % 10 == 0) wait_drained();
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (16) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
